/* hw/rtl/tgr_pkg.sv */
// shared types, constants and font table for the text glyph rasterizer
package tgr_pkg;

    localparam int GLYPH_SIZE = 8;
    localparam int GLYPH_BITS = GLYPH_SIZE * GLYPH_SIZE;
    localparam int POS_W      = $clog2(GLYPH_BITS);
    localparam int SUB_W      = $clog2(GLYPH_SIZE);
    localparam int COORD_W    = 16;
    localparam int PIX_W      = 10;
    localparam int DIM_W      = 11;
    localparam int COLOR_W    = 16;
    localparam int GIDX_W     = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] GLYPH_BASE   = 8'd32;
    localparam logic [7:0] FIRST_DRAWN  = 8'd33;
    localparam logic [7:0] LAST_DRAWN   = 8'd90;

    localparam logic [DIM_W-1:0] DIM_CAP        = 11'd1024;
    localparam logic [DIM_W-1:0] WIDTH_RESET    = 11'd320;
    localparam logic [DIM_W-1:0] HEIGHT_RESET   = 11'd480;

    // register indexes, taken from paddr[2]
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sd32767;
    localparam logic signed [COORD_W-1:0] STEP_LIMIT = 16'sd32759;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } screen_t;

    typedef struct packed {
        logic [GIDX_W-1:0]         glyph_idx;
        logic signed [COORD_W-1:0] col;
        logic signed [COORD_W-1:0] row;
        logic [COLOR_W-1:0]        color;
    } queue_entry_t;

    // saturating advance by one glyph
    function automatic logic signed [COORD_W-1:0] sat_step(input logic signed [COORD_W-1:0] a);
        logic signed [COORD_W-1:0] r;
        if (a > STEP_LIMIT)
            r = COORD_MAX;
        else
            r = a + 16'(GLYPH_SIZE);
        return r;
    endfunction

    // glyph bitmap, row 0 in the top byte, bit 7 of each byte is column 0
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [GIDX_W-1:0] idx);
        logic [GLYPH_BITS-1:0] g;
        unique case (idx)
            6'd1:  g = 64'h183C3C1818001800;
            6'd2:  g = 64'h3636000000000000;
            6'd3:  g = 64'h36367F367F363600;
            6'd4:  g = 64'h0C3E031E301F0C00;
            6'd5:  g = 64'h006333180C666300;
            6'd6:  g = 64'h1C361C6E3B336E00;
            6'd7:  g = 64'h0606030000000000;
            6'd8:  g = 64'h180C0606060C1800;
            6'd9:  g = 64'h060C1818180C0600;
            6'd10: g = 64'h00663CFF3C660000;
            6'd11: g = 64'h000C0C3F0C0C0000;
            6'd12: g = 64'h00000000000C0600;
            6'd13: g = 64'h0000003F00000000;
            6'd14: g = 64'h00000000000C0C00;
            6'd15: g = 64'h6030180C06030100;
            6'd16: g = 64'h3E63737B6F673E00;
            6'd17: g = 64'h0C0E0C0C0C0C3F00;
            6'd18: g = 64'h1E33301C06333F00;
            6'd19: g = 64'h1E33301C30331E00;
            6'd20: g = 64'h383C36337F307800;
            6'd21: g = 64'h3F031F3030331E00;
            6'd22: g = 64'h1C06031F33331E00;
            6'd23: g = 64'h3F3330180C0C0C00;
            6'd24: g = 64'h1E33331E33331E00;
            6'd25: g = 64'h1E33333E30180E00;
            6'd26: g = 64'h000C0C00000C0C00;
            6'd27: g = 64'h000C0C00000C0600;
            6'd28: g = 64'h180C0603060C1800;
            6'd29: g = 64'h00003F00003F0000;
            6'd30: g = 64'h060C1830180C0600;
            6'd31: g = 64'h1E3330180C000C00;
            6'd32: g = 64'h3E637B7B7B031E00;
            6'd33: g = 64'h0C1E33333F333300;
            6'd34: g = 64'h3F66663E66663F00;
            6'd35: g = 64'h3C66030303663C00;
            6'd36: g = 64'h1F36666666361F00;
            6'd37: g = 64'h7F46161E16467F00;
            6'd38: g = 64'h7F46161E16060F00;
            6'd39: g = 64'h3C66030373667C00;
            6'd40: g = 64'h3333333F33333300;
            6'd41: g = 64'h1E0C0C0C0C0C1E00;
            6'd42: g = 64'h7830303033331E00;
            6'd43: g = 64'h6766361E36666700;
            6'd44: g = 64'h0F06060646667F00;
            6'd45: g = 64'h63777F7F6B636300;
            6'd46: g = 64'h63676F7B73636300;
            6'd47: g = 64'h1C36636363361C00;
            6'd48: g = 64'h3F66663E06060F00;
            6'd49: g = 64'h1E3333333B1E3800;
            6'd50: g = 64'h3F66663E36666700;
            6'd51: g = 64'h1E33070E38331E00;
            6'd52: g = 64'h3F2D0C0C0C0C1E00;
            6'd53: g = 64'h3333333333333F00;
            6'd54: g = 64'h33333333331E0C00;
            6'd55: g = 64'h6363636B7F776300;
            6'd56: g = 64'h6363361C1C366300;
            6'd57: g = 64'h3333331E0C0C1E00;
            6'd58: g = 64'h7F6331184C667F00;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

/* hw/rtl/text_glyph_rasterizer.sv */
// first pixel path: an accepted item is written to the glyph queue, loaded into the scan
//   registers once the back end is idle, and registered at the output when the scan reaches its bit
// throughput: a drawn glyph takes a load step, then one glyph bit per cycle while the output
//   is not stalled, up to its last visible lit bit; newline, space and blank codes are not queued
// the front end accepts while the two-entry glyph queue has room; output stalls hold the scan
// reset: cursor, row and line start cleared to 0, width 320, height 480, queue and output empty
module text_glyph_rasterizer
    import tgr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                char_code,
    input  logic                      new_string,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic [COLOR_W-1:0]        ink_color,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [PIX_W-1:0]          pixel_x,
    output logic [PIX_W-1:0]          pixel_y,
    output logic [COLOR_W-1:0]        pixel_color,
    output logic                      last_of_glyph,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             cfg_write;
    screen_t          screen;
    logic             q_full, q_push, q_pop, q_valid;
    queue_entry_t     q_in, q_head;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SCREEN_WIDTH:  width_next  = pwdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: height_next = pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_SCREEN_WIDTH:  prdata = 32'(width_reg);
            REG_SCREEN_HEIGHT: prdata = 32'(height_reg);
            default:           prdata = '0;
        endcase
    end

    // screen limits capped to the output coordinate range
    assign screen.width  = (width_reg > DIM_CAP) ? DIM_CAP : width_reg;
    assign screen.height = (height_reg > DIM_CAP) ? DIM_CAP : height_reg;

    tgr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .new_string (new_string),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .ink_color  (ink_color),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    tgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    tgr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen        (screen),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_color   (pixel_color),
        .last_of_glyph (last_of_glyph)
    );

    // emitted pixels lie inside the clipped screen
    a_pixel_x_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, pixel_x} < screen.width))
        else $error("pixel column outside screen");

    a_pixel_y_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, pixel_y} < screen.height))
        else $error("pixel row outside screen");

    // a full queue stalls the input side
    a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_ready && !q_push)
        else $error("item accepted into full glyph queue");

endmodule

/* hw/rtl/tgr_front.sv */
// front end: accepts characters, tracks the cursor and queues drawable glyphs
module tgr_front
    import tgr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                char_code,
    input  logic                      new_string,
    input  logic signed [COORD_W-1:0] origin_x,
    input  logic signed [COORD_W-1:0] origin_y,
    input  logic [COLOR_W-1:0]        ink_color,
    input  logic                      q_full,
    output logic                      q_push,
    output queue_entry_t              q_data
);

    logic signed [COORD_W-1:0] cursor_col_reg, cursor_col_next;
    logic signed [COORD_W-1:0] cursor_row_reg, cursor_row_next;
    logic signed [COORD_W-1:0] line_start_reg, line_start_next;
    logic signed [COORD_W-1:0] cur_col, cur_row, cur_line;
    logic                      accept;
    logic                      drawable;
    logic [7:0]                glyph_off;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // cursor as seen by this item after an optional string restart
    always_comb
    begin
        if (new_string)
        begin
            cur_col  = origin_x;
            cur_row  = origin_y;
            cur_line = origin_x;
        end
        else
        begin
            cur_col  = cursor_col_reg;
            cur_row  = cursor_row_reg;
            cur_line = line_start_reg;
        end
    end

    // only codes with a non-blank glyph go to the back end
    assign drawable  = (char_code >= FIRST_DRAWN) && (char_code <= LAST_DRAWN);
    assign glyph_off = char_code - GLYPH_BASE;

    assign q_push           = accept && drawable;
    assign q_data.glyph_idx = glyph_off[GIDX_W-1:0];
    assign q_data.col       = cur_col;
    assign q_data.row       = cur_row;
    assign q_data.color     = ink_color;

    // cursor update
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        line_start_next = line_start_reg;
        if (accept)
        begin
            line_start_next = cur_line;
            if (char_code == NEWLINE_CODE)
            begin
                cursor_col_next = cur_line;
                cursor_row_next = sat_step(cur_row);
            end
            else
            begin
                cursor_col_next = sat_step(cur_col);
                cursor_row_next = cur_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            line_start_reg <= '0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            line_start_reg <= line_start_next;
        end
    end

endmodule

/* hw/rtl/tgr_queue.sv */
// two-entry queue between the front end and the rasterizer
module tgr_queue
    import tgr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output queue_entry_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    queue_entry_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]        count_reg, count_next;

    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* hw/rtl/tgr_back.sv */
// back end: clips one glyph to the screen and scans out its lit pixels
module tgr_back
    import tgr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  screen_t            screen,
    input  logic               q_valid,
    input  queue_entry_t       q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   pixel_x,
    output logic [PIX_W-1:0]   pixel_y,
    output logic [COLOR_W-1:0] pixel_color,
    output logic               last_of_glyph
);

    localparam int EXT_W = COORD_W + 2;

    logic                  busy_reg, busy_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [GLYPH_BITS-1:0] mask_reg, mask_next;
    logic [PIX_W-1:0]      col_reg, col_next;
    logic [PIX_W-1:0]      row_reg, row_next;
    logic [COLOR_W-1:0]    color_reg, color_next;

    logic                  out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]      pixel_x_reg, pixel_x_next;
    logic [PIX_W-1:0]      pixel_y_reg, pixel_y_next;
    logic [COLOR_W-1:0]    pixel_color_reg, pixel_color_next;
    logic                  last_reg, last_next;

    logic [GLYPH_SIZE-1:0] col_vis, row_vis;
    logic [GLYPH_BITS-1:0] glyph, load_mask, mask_clr;
    logic signed [EXT_W-1:0] px_ext, py_ext;
    logic                  advance, load;

    // per-column and per-row visibility of the glyph at the queue head
    always_comb
    begin
        px_ext = '0;
        py_ext = '0;
        for (int i = 0; i < GLYPH_SIZE; i++)
        begin
            px_ext = EXT_W'(q_head.col) + EXT_W'(i);
            py_ext = EXT_W'(q_head.row) + EXT_W'(i);
            col_vis[i] = !px_ext[EXT_W-1] && (px_ext[EXT_W-2:0] < (EXT_W-1)'(screen.width));
            row_vis[i] = !py_ext[EXT_W-1] && (py_ext[EXT_W-2:0] < (EXT_W-1)'(screen.height));
        end
    end

    // visible lit bits, bit r*8+c for row r and column c
    assign glyph = glyph_bits(q_head.glyph_idx);
    always_comb
    begin
        for (int r = 0; r < GLYPH_SIZE; r++)
        begin
            for (int c = 0; c < GLYPH_SIZE; c++)
            begin
                load_mask[r*GLYPH_SIZE + c] = glyph[GLYPH_BITS-1 - (r*GLYPH_SIZE + c)]
                                              && row_vis[r] && col_vis[c];
            end
        end
    end

    assign advance  = !out_valid_reg || out_ready;
    assign load     = !busy_reg && q_valid;
    assign q_pop    = load;
    assign mask_clr = mask_reg & ~(GLYPH_BITS'(1) << pos_reg);

    // scan sequencer and output register
    always_comb
    begin
        busy_next        = busy_reg;
        pos_next         = pos_reg;
        mask_next        = mask_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        color_next       = color_reg;
        out_valid_next   = out_valid_reg;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        pixel_color_next = pixel_color_reg;
        last_next        = last_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (load)
        begin
            busy_next  = (load_mask != '0);
            pos_next   = '0;
            mask_next  = load_mask;
            col_next   = q_head.col[PIX_W-1:0];
            row_next   = q_head.row[PIX_W-1:0];
            color_next = q_head.color;
        end
        else if (busy_reg && advance)
        begin
            if (mask_reg[pos_reg])
            begin
                out_valid_next   = 1'b1;
                pixel_x_next     = col_reg + PIX_W'(pos_reg[SUB_W-1:0]);
                pixel_y_next     = row_reg + PIX_W'(pos_reg[POS_W-1:SUB_W]);
                pixel_color_next = color_reg;
                last_next        = (mask_clr == '0);
            end
            mask_next = mask_clr;
            pos_next  = pos_reg + 1'b1;
            busy_next = (mask_clr != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        mask_reg        <= mask_next;
        col_reg         <= col_next;
        row_reg         <= row_next;
        color_reg       <= color_next;
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        pixel_color_reg <= pixel_color_next;
        last_reg        <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign pixel_color   = pixel_color_reg;
    assign last_of_glyph = last_reg;

endmodule
